// ===== rtl/tcie_pkg.sv =====
`default_nettype none
package tcie_pkg;

    // Storage sizes.
    localparam int STACK_DEPTH = 128;
    localparam int DATA_DEPTH  = 256;
    localparam int CODE_DEPTH  = 1024;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int DA_W        = $clog2(DATA_DEPTH);

    // Register map.
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_CODE_LEN = 2'd0;
    localparam logic [1:0] REG_DATA_LEN = 2'd1;
    localparam logic [1:0] REG_MEM_TOT  = 2'd2;

    // Opcodes.
    localparam logic [3:0] OP_MOV  = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_CMP  = 4'd2;
    localparam logic [3:0] OP_JMP  = 4'd3;
    localparam logic [3:0] OP_JZ   = 4'd4;
    localparam logic [3:0] OP_JNZ  = 4'd5;
    localparam logic [3:0] OP_HALT = 4'd6;
    localparam logic [3:0] OP_PUSH = 4'd7;
    localparam logic [3:0] OP_POP  = 4'd8;

    // Source modes.
    localparam logic [2:0] SRC_NONE = 3'd0;
    localparam logic [2:0] SRC_IMM  = 3'd1;
    localparam logic [2:0] SRC_REG  = 3'd2;
    localparam logic [2:0] SRC_DIR  = 3'd3;
    localparam logic [2:0] SRC_IND  = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_OPERR = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;

    localparam logic CMD_LOAD = 1'b0;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         opcode;
        logic               has_dest;
        logic [1:0]         dst_sel;
        logic [2:0]         src_mode;
        logic [1:0]         src_reg;
        logic signed [31:0] operand_value;
        logic [7:0]         data_addr;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] next_ip;
        logic               zero_flag;
        logic               sign_flag;
        logic signed [31:0] reg_a;
        logic signed [31:0] reg_b;
        logic signed [31:0] reg_c;
        logic signed [31:0] reg_d;
    } t_out_word;

    typedef struct packed {
        logic [10:0] code_length;
        logic [8:0]  data_length;
        logic [10:0] memory_total;
    } t_cfg;

endpackage
`default_nettype wire

// ===== rtl/tcie_ram.sv =====
`default_nettype none
module tcie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tcie_cfg.sv =====
`default_nettype none
module tcie_cfg
    import tcie_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);
    t_cfg r_cfg;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Register writes; unmapped addresses are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_length  <= '0;
            r_cfg.data_length  <= '0;
            r_cfg.memory_total <= 11'(CODE_DEPTH);
        end else if (wr) begin
            case (paddr[3:2])
                REG_CODE_LEN: r_cfg.code_length  <= pwdata[10:0];
                REG_DATA_LEN: r_cfg.data_length  <= pwdata[8:0];
                REG_MEM_TOT:  r_cfg.memory_total <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (paddr[3:2])
            REG_CODE_LEN: prdata = {21'd0, r_cfg.code_length};
            REG_DATA_LEN: prdata = {23'd0, r_cfg.data_length};
            REG_MEM_TOT:  prdata = {21'd0, r_cfg.memory_total};
            default:      prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/toy_cpu_instruction_executor.sv =====
`default_nettype none
// Executes one pre-decoded instruction or one data load per input word and
// returns one result word with status, next pointer, flags and the four
// registers. Each word first issues the read of the data and stack memories
// (registered read) when accepted, then executes and writes back. A new word
// is taken once the previous one has executed, even while its result still
// waits in the output register; execution waits only if that register is
// still full. Data store entries carry valid bits cleared by reset.
module toy_cpu_instruction_executor
    import tcie_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_word           i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_word               o_out_word,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_cfg        cfg;
    t_state      r_state, n_state;
    t_in_word    r_item;
    logic [31:0] r_maddr;
    logic        r_mvalid;
    logic [31:0] r_regs [4];
    logic [31:0] n_regs [4];
    logic [31:0] r_ip, n_ip;
    logic        r_zf, n_zf, r_sf, n_sf;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [DATA_DEPTH-1:0] r_valid;
    logic        r_out_valid;
    t_out_word   r_out;

    logic        accept, out_free, exec;
    logic        d_we, s_we, set_valid;
    logic [DA_W-1:0] d_waddr;
    logic [31:0] d_wdata, d_rdata, s_rdata, s_wdata;
    logic [DA_W-1:0] d_raddr;
    logic [31:0] in_maddr;
    logic [2:0]  status;

    tcie_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign exec        = (r_state == S_EXEC) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Memory operand address, taken from the incoming word.
    assign in_maddr = (i_in_word.src_mode == SRC_DIR) ? i_in_word.operand_value
                                                      : r_regs[i_in_word.src_reg];
    assign d_raddr  = in_maddr[DA_W-1:0];

    tcie_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_data (
        .i_clk, .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_re(accept), .i_raddr(d_raddr), .o_rdata(d_rdata)
    );

    tcie_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk, .i_we(s_we), .i_waddr(r_sp - SP_W'(1)), .i_wdata(s_wdata),
        .i_re(accept), .i_raddr(r_sp), .o_rdata(s_rdata)
    );

    // Execute stage.
    always_comb begin
        logic        mem_ok, is_none, is_mem, src_err;
        logic [31:0] val, sum, diff, ip1;
        n_regs    = r_regs;
        n_ip      = r_ip;
        n_zf      = r_zf;
        n_sf      = r_sf;
        n_sp      = r_sp;
        status    = ST_OK;
        d_we      = 1'b0;
        d_waddr   = r_item.data_addr[DA_W-1:0];
        d_wdata   = r_item.operand_value;
        set_valid = 1'b0;
        s_we      = 1'b0;
        s_wdata   = r_regs[0];
        mem_ok    = !r_maddr[31] && (r_maddr[30:11] == '0)
                    && (r_maddr[10:0] < cfg.memory_total)
                    && (r_maddr < {23'd0, cfg.data_length})
                    && (r_maddr < 32'(DATA_DEPTH))
                    && r_mvalid;
        is_none   = (r_item.src_mode == SRC_NONE);
        is_mem    = (r_item.src_mode == SRC_DIR) || (r_item.src_mode == SRC_IND);
        src_err   = (r_item.src_mode > SRC_IND) || (is_mem && !mem_ok);
        case (r_item.src_mode)
            SRC_IMM: val = r_item.operand_value;
            SRC_REG: val = r_regs[r_item.src_reg];
            SRC_DIR, SRC_IND: val = d_rdata;
            default: val = '0;
        endcase
        sum  = r_regs[r_item.dst_sel] + val;
        diff = r_regs[r_item.dst_sel] - val;
        ip1  = r_ip + 32'd1;

        if (r_item.cmd == CMD_LOAD) begin
            if ({1'b0, r_item.data_addr} < cfg.data_length) begin
                d_we      = 1'b1;
                set_valid = 1'b1;
            end else begin
                status = ST_OPERR;
            end
        end else if (r_ip[31] || (r_ip[30:11] != '0) || (r_ip[10:0] >= cfg.code_length)
                     || (r_ip >= 32'(CODE_DEPTH))) begin
            status = ST_END;
        end else begin
            n_ip = ip1;
            if (src_err || (r_item.has_dest && is_none)) begin
                status = ST_OPERR;
            end else begin
                case (r_item.opcode)
                    OP_MOV, OP_ADD, OP_CMP: begin
                        if (!r_item.has_dest) begin
                            status = ST_OPERR;
                        end else if (r_item.opcode == OP_MOV) begin
                            n_regs[r_item.dst_sel] = val;
                        end else if (r_item.opcode == OP_ADD) begin
                            n_regs[r_item.dst_sel] = sum;
                        end else begin
                            n_zf = (diff == '0);
                            n_sf = diff[31];
                        end
                    end
                    OP_JMP, OP_JZ, OP_JNZ: begin
                        if (is_none) begin
                            status = ST_OPERR;
                        end else if ((r_item.opcode == OP_JMP)
                                     || ((r_item.opcode == OP_JZ) && r_zf)
                                     || ((r_item.opcode == OP_JNZ) && !r_zf)) begin
                            n_ip = val;
                        end
                    end
                    OP_HALT: n_ip = '1;
                    OP_PUSH: begin
                        if (r_sp == '0) begin
                            status = ST_FULL;
                        end else begin
                            s_we    = 1'b1;
                            s_wdata = is_none ? r_regs[0] : val;
                            n_sp    = r_sp - SP_W'(1);
                        end
                    end
                    OP_POP: begin
                        if (r_sp == SP_W'(STACK_DEPTH - 1)) begin
                            status = ST_EMPTY;
                        end else begin
                            n_sp = r_sp + SP_W'(1);
                            if (is_none) begin
                                n_regs[0] = s_rdata;
                            end else if (r_item.src_mode == SRC_REG) begin
                                n_regs[r_item.src_reg] = s_rdata;
                            end else if (is_mem) begin
                                d_we    = 1'b1;
                                d_waddr = r_maddr[DA_W-1:0];
                                d_wdata = s_rdata;
                            end
                        end
                    end
                    default: status = ST_OPERR;
                endcase
            end
        end
        if (!exec) begin
            d_we      = 1'b0;
            s_we      = 1'b0;
            set_valid = 1'b0;
        end
    end

    // Sequencer.
    always_comb begin
        case (r_state)
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = exec ? S_IDLE : S_EXEC;
            default: n_state = S_IDLE;
        endcase
    end

    // Architectural state and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_regs      <= '{default: '0};
            r_ip        <= '0;
            r_zf        <= 1'b0;
            r_sf        <= 1'b0;
            r_sp        <= SP_W'(STACK_DEPTH - 1);
            r_valid     <= '0;
        end else begin
            r_state <= n_state;
            if (exec) begin
                r_out_valid <= 1'b1;
                r_regs      <= n_regs;
                r_ip        <= n_ip;
                r_zf        <= n_zf;
                r_sf        <= n_sf;
                r_sp        <= n_sp;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (set_valid) begin
                r_valid[r_item.data_addr[DA_W-1:0]] <= 1'b1;
            end
        end
    end

    // Item and result payload; the valid bit of the operand entry is read here.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item   <= i_in_word;
            r_maddr  <= in_maddr;
            r_mvalid <= r_valid[in_maddr[DA_W-1:0]];
        end
        if (exec) begin
            r_out.status    <= status;
            r_out.next_ip   <= n_ip;
            r_out.zero_flag <= n_zf;
            r_out.sign_flag <= n_sf;
            r_out.reg_a     <= n_regs[0];
            r_out.reg_b     <= n_regs[1];
            r_out.reg_c     <= n_regs[2];
            r_out.reg_d     <= n_regs[3];
        end
    end

    // An accepted word always moves on to execution.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted word did not enter execution");

    // Execution holds only while the output register is full and stalled.
    a_exec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && !exec) |-> (r_out_valid && i_out_stall))
        else $error("execution held without a stalled result");

    // A new result appears only after an execute cycle.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(exec))
        else $error("result produced without execution");

    // The instruction and stack pointers change only in an execute cycle.
    a_state_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !exec |=> ($stable(r_ip) && $stable(r_sp)))
        else $error("state changed outside execution");
endmodule
`default_nettype wire

// ===== tb/tcie_checker.sv =====
`timescale 1ns / 1ps
module tcie_checker
    import tcie_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire t_in_word           i_in_word,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire t_out_word          i_out_word,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic               i_pready,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [31:0]        i_pwdata,
    output int                      o_errors,
    output int                      o_pending
);

    // Machine state as the predictor sees it.
    logic [31:0] gp_regs [4];
    logic [31:0] ip;
    logic        zf;
    logic        sf;
    int          sp;
    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] data_mem [DATA_DEPTH];
    bit          data_ok [DATA_DEPTH];
    logic [10:0] code_len;
    logic [8:0]  data_len;
    logic [10:0] mem_tot;

    t_out_word   expected_results [$];

    assign o_pending = expected_results.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic bit mem_readable(input logic [31:0] a);
        if (a[31] || a >= mem_tot || a >= data_len || a >= DATA_DEPTH) return 0;
        return data_ok[a[7:0]];
    endfunction

    // Executes one instruction against the model state and returns its status.
    function automatic logic [2:0] run_instr(input t_in_word w);
        logic [31:0] val;
        logic [31:0] idx;
        logic [31:0] diff;
        logic [31:0] pv;
        bit          no_src;
        bit          is_reg;
        bit          is_mem;
        val = '0;
        idx = '0;
        no_src = 0;
        is_reg = 0;
        is_mem = 0;
        case (w.src_mode)
            SRC_NONE: no_src = 1;
            SRC_IMM:  val = w.operand_value;
            SRC_REG: begin
                idx = 32'(w.src_reg);
                val = gp_regs[w.src_reg];
                is_reg = 1;
            end
            SRC_DIR, SRC_IND: begin
                idx = (w.src_mode == SRC_DIR) ? w.operand_value : gp_regs[w.src_reg];
                if (!mem_readable(idx)) return ST_OPERR;
                val = data_mem[idx[7:0]];
                is_mem = 1;
            end
            default: return ST_OPERR;
        endcase
        if (w.has_dest && no_src) return ST_OPERR;
        case (w.opcode)
            OP_MOV, OP_ADD, OP_CMP: begin
                if (!w.has_dest) return ST_OPERR;
                if (w.opcode == OP_MOV) begin
                    gp_regs[w.dst_sel] = val;
                end else if (w.opcode == OP_ADD) begin
                    gp_regs[w.dst_sel] = gp_regs[w.dst_sel] + val;
                end else begin
                    diff = gp_regs[w.dst_sel] - val;
                    zf = (diff == 0);
                    sf = diff[31];
                end
                return ST_OK;
            end
            OP_JMP, OP_JZ, OP_JNZ: begin
                if (no_src) return ST_OPERR;
                if (w.opcode == OP_JMP || (w.opcode == OP_JZ && zf) ||
                    (w.opcode == OP_JNZ && !zf))
                    ip = val;
                return ST_OK;
            end
            OP_HALT: begin
                ip = 32'hFFFF_FFFF;
                return ST_OK;
            end
            OP_PUSH: begin
                pv = no_src ? gp_regs[0] : val;
                if (sp == 0) return ST_FULL;
                sp--;
                stack_mem[sp] = pv;
                return ST_OK;
            end
            OP_POP: begin
                if (sp >= STACK_DEPTH - 1) return ST_EMPTY;
                pv = stack_mem[sp];
                sp++;
                if (no_src) gp_regs[0] = pv;
                else if (is_reg) gp_regs[idx[1:0]] = pv;
                else if (is_mem) data_mem[idx[7:0]] = pv;
                return ST_OK;
            end
            default: return ST_OPERR;
        endcase
    endfunction

    // Works out the result word that one accepted input word causes.
    function automatic t_out_word execute_word(input t_in_word w);
        t_out_word r;
        logic [2:0] st;
        if (w.cmd == CMD_LOAD) begin
            if (w.data_addr < data_len) begin
                data_mem[w.data_addr] = w.operand_value;
                data_ok[w.data_addr] = 1;
                st = ST_OK;
            end else begin
                st = ST_OPERR;
            end
        end else if (ip[31] || ip >= code_len || ip >= CODE_DEPTH) begin
            st = ST_END;
        end else begin
            ip = ip + 1;
            st = run_instr(w);
        end
        r.status = st;
        r.next_ip = ip;
        r.zero_flag = zf;
        r.sign_flag = sf;
        r.reg_a = gp_regs[0];
        r.reg_b = gp_regs[1];
        r.reg_c = gp_regs[2];
        r.reg_d = gp_regs[3];
        return r;
    endfunction

    initial o_errors = 0;

    // Compare finished words first, then predict the word taken at this edge.
    always @(posedge i_clk) begin
        t_out_word w;
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) gp_regs[k] = '0;
            for (int k = 0; k < DATA_DEPTH; k++) data_ok[k] = 0;
            ip = '0;
            zf = 0;
            sf = 0;
            sp = STACK_DEPTH - 1;
            code_len = '0;
            data_len = '0;
            mem_tot = 11'd1024;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report("unexpected word", i_out_word.status, '0);
                end else begin
                    w = expected_results.pop_front();
                    if (i_out_word.status !== w.status)
                        report("status", i_out_word.status, w.status);
                    if (i_out_word.next_ip !== w.next_ip)
                        report("next_ip", i_out_word.next_ip, w.next_ip);
                    if (i_out_word.zero_flag !== w.zero_flag)
                        report("zero_flag", i_out_word.zero_flag, w.zero_flag);
                    if (i_out_word.sign_flag !== w.sign_flag)
                        report("sign_flag", i_out_word.sign_flag, w.sign_flag);
                    if (i_out_word.reg_a !== w.reg_a) report("reg_a", i_out_word.reg_a, w.reg_a);
                    if (i_out_word.reg_b !== w.reg_b) report("reg_b", i_out_word.reg_b, w.reg_b);
                    if (i_out_word.reg_c !== w.reg_c) report("reg_c", i_out_word.reg_c, w.reg_c);
                    if (i_out_word.reg_d !== w.reg_d) report("reg_d", i_out_word.reg_d, w.reg_d);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(execute_word(i_in_word));
            // Register writes land at the access phase.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_CODE_LEN: code_len = i_pwdata[10:0];
                    REG_DATA_LEN: data_len = i_pwdata[8:0];
                    REG_MEM_TOT:  mem_tot = i_pwdata[10:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import tcie_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_word           i_in_word;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_word          o_out_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 errors;
    int                 pending;
    int                 words_sent;
    bit                 quiet;

    toy_cpu_instruction_executor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tcie_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_word(i_in_word),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_word(o_out_word),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic t_in_word exec_word(input logic [3:0] op, input bit hd,
                                           input logic [1:0] dr, input logic [2:0] mode,
                                           input logic [1:0] sr, input logic [31:0] v);
        t_in_word w;
        w.cmd = 1'b1;
        w.opcode = op;
        w.has_dest = hd;
        w.dst_sel = dr;
        w.src_mode = mode;
        w.src_reg = sr;
        w.operand_value = v;
        w.data_addr = 8'($urandom);
        return w;
    endfunction

    function automatic t_in_word load_word(input logic [7:0] a, input logic [31:0] v);
        t_in_word w;
        w = exec_word(4'($urandom), 1'($urandom), 2'($urandom), 3'($urandom),
                      2'($urandom), v);
        w.cmd = CMD_LOAD;
        w.data_addr = a;
        return w;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 300);
            1: return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    // Random word; without wild, jumps stay near the start and HALT is left out
    // so the program keeps running.
    function automatic t_in_word random_word(input bit wild);
        logic [3:0] op;
        logic [2:0] mode;
        if ($urandom_range(0, 99) < 20)
            return load_word(8'(($urandom_range(0, 9) < 6) ? $urandom_range(0, 31) : $urandom),
                             pick_value());
        op = 4'(($urandom_range(0, 19) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8));
        mode = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
        if (!wild && op == OP_HALT) op = OP_MOV;
        if (!wild && (op == OP_JMP || op == OP_JZ || op == OP_JNZ))
            return exec_word(op, $urandom_range(0, 3) == 0, 2'($urandom), SRC_IMM,
                             2'($urandom), $urandom_range(0, 100));
        return exec_word(op, $urandom_range(0, 99) < 85, 2'($urandom), mode, 2'($urandom),
                         (mode == SRC_DIR) ? $urandom_range(0, 40) : pick_value());
    endfunction

    task automatic send(input t_in_word w);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        gap = (quiet || r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] v);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // The extra edge lets the checker record the last accepted word first.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_run(input int n, input bit wild);
        repeat (n) begin
            if ($urandom_range(0, 49) == 0) quiet = !quiet;
            send(random_word(wild));
        end
    endtask

    // Result side stall: changing density, plus one long hold-off.
    initial begin
        int pct;
        bit held;
        held = 0;
        pct = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && words_sent >= 300) begin
                held = 1;
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
            end
            if ($urandom_range(0, 63) == 0) begin
                case ($urandom_range(0, 3))
                    0: pct = 0;
                    1: pct = 20;
                    2: pct = 50;
                    default: pct = 90;
                endcase
            end
            i_out_stall <= ($urandom_range(0, 99) < pct);
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        words_sent = 0;
        quiet = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: program length zero and no data segment.
        send(exec_word(OP_MOV, 1, 0, SRC_IMM, 0, 32'd1));
        send(load_word(8'd0, 32'd9));
        drain();
        cfg_write(REG_CODE_LEN, 32'd1024);
        cfg_write(REG_DATA_LEN, 32'd256);
        cfg_write(REG_MEM_TOT, 32'd1024);

        // Directed words: extremes, every opcode but HALT and the error cases.
        send(load_word(8'd0, 32'h7FFF_FFFF));
        send(load_word(8'd255, 32'h8000_0000));
        send(load_word(8'd5, 32'd5));
        send(exec_word(OP_MOV, 1, 0, SRC_IMM, 0, 32'h8000_0000));
        send(exec_word(OP_MOV, 1, 1, SRC_IMM, 0, 32'h7FFF_FFFF));
        send(exec_word(OP_ADD, 1, 1, SRC_IMM, 0, 32'd1));
        send(exec_word(OP_ADD, 1, 0, SRC_REG, 0, 32'd0));
        send(exec_word(OP_MOV, 1, 2, SRC_DIR, 0, 32'd255));
        send(exec_word(OP_MOV, 1, 3, SRC_IND, 2, 32'd0));
        send(exec_word(OP_MOV, 1, 3, SRC_IMM, 0, 32'd5));
        send(exec_word(OP_MOV, 1, 2, SRC_IND, 3, 32'd0));
        send(exec_word(OP_CMP, 1, 0, SRC_IMM, 0, 32'd0));
        send(exec_word(OP_CMP, 1, 2, SRC_IMM, 0, 32'd6));
        send(exec_word(OP_JZ, 0, 0, SRC_IMM, 0, 32'd3));
        send(exec_word(OP_JNZ, 0, 0, SRC_IMM, 0, 32'd2));
        send(exec_word(OP_MOV, 1, 0, SRC_DIR, 0, 32'd1));
        send(exec_word(OP_MOV, 1, 0, SRC_DIR, 0, 32'd300));
        send(exec_word(OP_MOV, 1, 0, 3'd5, 0, 32'd0));
        send(exec_word(OP_MOV, 1, 0, SRC_NONE, 0, 32'd0));
        send(exec_word(OP_ADD, 0, 0, SRC_IMM, 0, 32'd1));
        send(exec_word(OP_JMP, 0, 0, SRC_NONE, 0, 32'd0));
        send(exec_word(4'd12, 0, 0, SRC_IMM, 0, 32'd0));
        send(exec_word(OP_PUSH, 0, 0, SRC_NONE, 0, 32'd0));
        send(exec_word(OP_PUSH, 0, 0, SRC_IMM, 0, 32'hFFFF_FFFF));
        send(exec_word(OP_POP, 0, 0, SRC_IMM, 0, 32'd0));
        send(exec_word(OP_POP, 0, 0, SRC_DIR, 0, 32'd5));
        send(exec_word(OP_POP, 0, 0, SRC_NONE, 0, 32'd0));
        send(exec_word(OP_JMP, 0, 0, SRC_IMM, 0, 32'd0));

        // Fill the stack past full, then empty it past empty.
        repeat (STACK_DEPTH)
            send(exec_word(OP_PUSH, 0, 0, 3'($urandom_range(0, 2)), 2'($urandom),
                           pick_value()));
        repeat (STACK_DEPTH)
            send(exec_word(OP_POP, 0, 0, ($urandom_range(0, 1) ? SRC_REG : SRC_NONE),
                           2'($urandom), 32'd0));
        send(exec_word(OP_JMP, 0, 0, SRC_IMM, 0, 32'd0));

        random_run(60, 0);
        drain();
        cfg_write(REG_DATA_LEN, 32'd16);
        cfg_write(REG_MEM_TOT, 32'd8);
        random_run(30, 0);
        drain();
        cfg_write(REG_CODE_LEN, 32'd0);
        random_run(10, 0);
        drain();
        cfg_write(REG_CODE_LEN, 32'd1024);
        cfg_write(REG_DATA_LEN, 32'd256);
        cfg_write(REG_MEM_TOT, 32'd0);
        send(exec_word(OP_JMP, 0, 0, SRC_IMM, 0, 32'd0));
        random_run(10, 0);
        drain();
        cfg_write(REG_MEM_TOT, 32'd1024);
        random_run(50, 1);
        send(exec_word(OP_HALT, 0, 0, SRC_NONE, 0, 32'd0));
        send(exec_word(OP_MOV, 1, 0, SRC_IMM, 0, 32'd1));

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
